FILE: rtl/pcb_pkg.sv
// package with word types, register indexes and constants of the palette blitter
`timescale 1ns / 1ps

package pcb_pkg;

  localparam int unsigned DimW    = 13;
  localparam int unsigned OriginW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned OutAddrW = 24;

  localparam logic [ChanW-1:0] KEY_CODE = 8'hff;

  localparam logic [DimW-1:0] STRIDE_RESET = 13'd320;
  localparam logic [DimW-1:0] DIM_RESET    = 13'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SURFACE_STRIDE = 3'd0,
    REG_ORIGIN_X       = 3'd1,
    REG_ORIGIN_Y       = 3'd2,
    REG_PIC_WIDTH      = 3'd3,
    REG_PIC_HEIGHT     = 3'd4
  } pcb_reg_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } pcb_req_e;

  typedef struct packed {
    logic             req_type;
    logic [ChanW-1:0] entry_slot;
    logic [ChanW-1:0] entry_red;
    logic [ChanW-1:0] entry_green;
    logic [ChanW-1:0] entry_blue;
    logic [ChanW-1:0] pixel_code;
  } pcb_in_t;

  typedef struct packed {
    logic [OutAddrW-1:0] pixel_address;
    logic [ColorW-1:0]   pixel_color;
    logic                write_enable;
    logic                last_pixel;
  } pcb_out_t;

endpackage

FILE: rtl/pcb_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pcb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pcb_walker.sv
// blit registers, row/column counters and the registered address product
`timescale 1ns / 1ps

module pcb_walker
  import pcb_pkg::*;
#(
  parameter int unsigned CoordBits = 12,
  parameter int unsigned SumW      = ((CoordBits > OriginW) ? CoordBits : OriginW) + 1,
  parameter int unsigned ProdW     = SumW + DimW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               step_i,
  output logic [ProdW-1:0]   prod_o,
  output logic [SumW-1:0]    offs_o,
  output logic               last_o
);

  localparam int unsigned CmpW = ((CoordBits > DimW) ? CoordBits : DimW) + 2;
  localparam logic [CmpW-1:0] Span = CmpW'(1) << CoordBits;

  logic [DimW-1:0]      stride_q, pw_q, ph_q;
  logic [OriginW-1:0]   ox_q, oy_q;
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic [ProdW-1:0]     prod_q;
  logic [SumW-1:0]      offs_q;
  logic                 last_q;

  logic [CmpW-1:0] w_eff, h_eff, w_ext, h_ext;
  logic            row_end, last;
  logic [SumW-1:0] ysum;
  logic            cfg_hit;

  always_comb begin
    w_ext = CmpW'(pw_q);
    h_ext = CmpW'(ph_q);
    // zero acts as one, oversize as the full coordinate span
    if (pw_q == '0) begin
      w_eff = CmpW'(1);
    end else if (w_ext > Span) begin
      w_eff = Span;
    end else begin
      w_eff = w_ext;
    end
    if (ph_q == '0) begin
      h_eff = CmpW'(1);
    end else if (h_ext > Span) begin
      h_eff = Span;
    end else begin
      h_eff = h_ext;
    end
    row_end = (CmpW'(col_q) + CmpW'(1)) >= w_eff;
    last    = row_end && ((CmpW'(row_q) + CmpW'(1)) >= h_eff);
    ysum    = SumW'(oy_q) + SumW'(row_q);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + CoordBits'(1);
    end else begin
      col_d = col_q + CoordBits'(1);
    end
  end

  always_comb begin
    unique case (cfg_index_i)
      REG_SURFACE_STRIDE, REG_ORIGIN_X, REG_ORIGIN_Y,
      REG_PIC_WIDTH, REG_PIC_HEIGHT: cfg_hit = cfg_we_i;
      default:                       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RESET;
      ox_q     <= '0;
      oy_q     <= '0;
      pw_q     <= DIM_RESET;
      ph_q     <= DIM_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SURFACE_STRIDE: stride_q <= cfg_wdata_i;
          REG_ORIGIN_X:       ox_q     <= cfg_wdata_i[OriginW-1:0];
          REG_ORIGIN_Y:       oy_q     <= cfg_wdata_i[OriginW-1:0];
          REG_PIC_WIDTH:      pw_q     <= cfg_wdata_i;
          REG_PIC_HEIGHT:     ph_q     <= cfg_wdata_i;
          default:            ;
        endcase
      end
      // any register write restarts the picture
      if (cfg_hit) begin
        col_q <= '0;
        row_q <= '0;
      end else if (step_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      prod_q <= ProdW'(ysum) * ProdW'(stride_q);
      offs_q <= SumW'(ox_q) + SumW'(col_q);
      last_q <= last;
    end
  end

  assign prod_o = prod_q;
  assign offs_o = offs_q;
  assign last_o = last_q;

endmodule

FILE: rtl/palette_color_key_blitter_core.sv
// top level of the palettized color-key blitter
`timescale 1ns / 1ps

// channel | direction | handshake                 | word
// cfg     | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
// in      | in        | in_valid_i / in_ready_o   | in_word_i (pcb_in_t)
// out     | out       | out_valid_o / out_ready_i | out_word_o (pcb_out_t)
//
// one input word per clock while in_ready_o is high; a pixel's result passes the
// registered palette ram read plus stride multiply, then the output register
// palette loads write the ram at accept and give no result
// reset clears counters and pipeline valids; palette contents stay undefined
// a stalled output holds the word; input stays ready while the middle stage can move

module palette_color_key_blitter_core
  import pcb_pkg::*;
#(
  parameter int unsigned PaletteEntries = 256,
  parameter int unsigned CoordBits      = 12,
  parameter int unsigned AddrBits       = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pcb_in_t            in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pcb_out_t           out_word_o
);

  localparam int unsigned IdxW  = $clog2(PaletteEntries);
  localparam int unsigned SumW  = ((CoordBits > OriginW) ? CoordBits : OriginW) + 1;
  localparam int unsigned ProdW = SumW + DimW;
  localparam int unsigned AddrW0 = (ProdW + 1 > AddrBits) ? ProdW + 1 : AddrBits;
  localparam int unsigned AddrW = (AddrW0 > OutAddrW) ? AddrW0 : OutAddrW;
  localparam logic [AddrW-1:0] AddrMask = AddrW'((65'(1) << AddrBits) - 65'(1));

  logic in_acc, pix_acc, load_we;
  logic s1_valid_q, s1_zero_q, s1_key_q;
  logic out_valid_q;
  logic out_free, s1_free, s1_move;
  pcb_out_t out_q;

  logic [ColorW-1:0] rdata;
  logic [ProdW-1:0]  prod;
  logic [SumW-1:0]   offs;
  logic              last;
  logic [AddrW-1:0]  addr_full;
  logic              code_key, code_oob;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || out_free;

  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && s1_free;
  assign pix_acc    = in_acc && (in_word_i.req_type == REQ_PIXEL);
  assign load_we    = in_acc && (in_word_i.req_type == REQ_LOAD)
                      && ({1'b0, in_word_i.entry_slot} < 9'(PaletteEntries));

  assign code_key = in_word_i.pixel_code == KEY_CODE;
  assign code_oob = {1'b0, in_word_i.pixel_code} >= 9'(PaletteEntries);

  // a load and a pixel never share a cycle, so the read never races a write
  pcb_ram #(
    .Width(ColorW),
    .Depth(PaletteEntries)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (in_word_i.entry_slot[IdxW-1:0]),
    .wdata_i ({in_word_i.entry_red, in_word_i.entry_green, in_word_i.entry_blue}),
    .re_i    (pix_acc),
    .raddr_i (in_word_i.pixel_code[IdxW-1:0]),
    .rdata_o (rdata)
  );

  pcb_walker #(
    .CoordBits(CoordBits),
    .SumW     (SumW),
    .ProdW    (ProdW)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (pix_acc),
    .prod_o      (prod),
    .offs_o      (offs),
    .last_o      (last)
  );

  assign addr_full = (AddrW'(prod) + AddrW'(offs)) & AddrMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= pix_acc;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_key_q  <= code_key;
      s1_zero_q <= code_key || code_oob;
    end
    if (s1_move) begin
      out_q.pixel_address <= addr_full[OutAddrW-1:0];
      out_q.pixel_color   <= s1_zero_q ? '0 : rdata;
      out_q.write_enable  <= !s1_key_q;
      out_q.last_pixel    <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
